// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the oriented box trigger.
// A use of a macro stands on a line of its own, with no trailing semicolon.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising clock edge while out of reset.
`define OBPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("obpt assertion failed");

// Checked on every rising clock edge, also during reset.
`define OBPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("obpt assertion failed");

`else

`define OBPT_ASSERT(lbl, prop)
`define OBPT_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/obpt_pkg.sv -----
`timescale 1ns / 1ps

package obpt_pkg;

  localparam int MAX_PARTICLES = 65536;
  localparam int COUNT_FIELD_MAX = 131071;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_PARTICLES < COUNT_FIELD_MAX) ? MAX_PARTICLES : COUNT_FIELD_MAX);

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X  = 4'd0,
    CFG_CENTER_Y  = 4'd1,
    CFG_CENTER_Z  = 4'd2,
    CFG_EXTENT_X  = 4'd3,
    CFG_EXTENT_Y  = 4'd4,
    CFG_EXTENT_Z  = 4'd5,
    CFG_ROTATION  = 4'd6,
    CFG_MIN_COUNT = 4'd7
  } cfg_idx_t;

  localparam logic [30:0] EXTENT_RESET = 31'd6553600;
  localparam logic [63:0] ROTATION_RESET = 64'h4000_0000_0000_0000;
  localparam logic [CNT_W-1:0] MIN_COUNT_RESET = 17'd1;

  // Q6.28 matrix entry and Q17.16 difference widths
  localparam int MAT_W = 34;
  localparam int DIFF_W = 33;
  localparam int HALF_W = 17;
  localparam int PROD_W = MAT_W + HALF_W;
  localparam int ACC_W = 69;
  localparam int FRAC_SHIFT = 28;
  localparam int LOC_W = ACC_W - FRAC_SHIFT;

  localparam logic signed [MAT_W-1:0] MAT_ONE = 34'sd268435456;
  localparam logic signed [ACC_W-1:0] ROUND_INIT = 69'sd134217728;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [2:0] MAC_LAST = 3'd5;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef struct packed {
    logic [2:0][31:0]            center;
    logic [2:0][30:0]            extent;
    logic [CNT_W-1:0]            min_count;
    logic [2:0][2:0][MAT_W-1:0]  mat;
  } cfg_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] d;
    logic [15:0]            index;
    logic                   has;
    logic                   last;
  } q_word_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN,
    BK_CHECK,
    BK_FINISH
  } bk_state_t;

endpackage

// ----- rtl/obpt_in_if.sv -----
`timescale 1ns / 1ps

interface obpt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        particle_index;
  logic               has_particle;
  logic               frame_last;

  modport source (
    output valid, pos_x, pos_y, pos_z, particle_index, has_particle, frame_last,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, particle_index, has_particle, frame_last,
    output ready
  );
endinterface

// ----- rtl/obpt_out_if.sv -----
`timescale 1ns / 1ps

interface obpt_out_if;
  logic        valid;
  logic        ready;
  logic        inside_res;
  logic [15:0] index_out;
  logic        frame_done;
  logic [16:0] frame_count;
  logic        triggered_now;
  logic        enter_event;
  logic        exit_event;

  modport source (
    output valid, inside_res, index_out, frame_done, frame_count, triggered_now,
           enter_event, exit_event,
    input  ready
  );

  modport sink (
    input  valid, inside_res, index_out, frame_done, frame_count, triggered_now,
           enter_event, exit_event,
    output ready
  );
endinterface

// ----- rtl/obpt_cfg_if.sv -----
`timescale 1ns / 1ps

interface obpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/obpt_cfg.sv -----
`timescale 1ns / 1ps

module obpt_cfg (
  input  logic              clk,
  input  logic              rst_n,
  obpt_cfg_if.sink          cfg_ch,
  output obpt_pkg::cfg_t    cfg
);

  logic [2:0][31:0]               center_r;
  logic [2:0][30:0]               extent_r;
  logic [63:0]                    rot_r;
  logic [obpt_pkg::CNT_W-1:0]     min_count_r;

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_xz_r, p_yz_r;
  logic signed [31:0] p_wx_r, p_wy_r, p_wz_r;

  logic signed [obpt_pkg::MAT_W-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz;
  logic signed [obpt_pkg::MAT_W-1:0] e_wx, e_wy, e_wz;
  logic signed [obpt_pkg::MAT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic [2:0][2:0][obpt_pkg::MAT_W-1:0] mat_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= '0;
      extent_r    <= {3{obpt_pkg::EXTENT_RESET}};
      rot_r       <= obpt_pkg::ROTATION_RESET;
      min_count_r <= obpt_pkg::MIN_COUNT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        obpt_pkg::CFG_CENTER_X:  center_r[0]  <= cfg_ch.data[31:0];
        obpt_pkg::CFG_CENTER_Y:  center_r[1]  <= cfg_ch.data[31:0];
        obpt_pkg::CFG_CENTER_Z:  center_r[2]  <= cfg_ch.data[31:0];
        obpt_pkg::CFG_EXTENT_X:  extent_r[0]  <= cfg_ch.data[30:0];
        obpt_pkg::CFG_EXTENT_Y:  extent_r[1]  <= cfg_ch.data[30:0];
        obpt_pkg::CFG_EXTENT_Z:  extent_r[2]  <= cfg_ch.data[30:0];
        obpt_pkg::CFG_ROTATION:  rot_r        <= cfg_ch.data;
        obpt_pkg::CFG_MIN_COUNT: min_count_r  <= cfg_ch.data[16:0];
        default: begin
        end
      endcase
    end
  end

  assign qx = rot_r[15:0];
  assign qy = rot_r[31:16];
  assign qz = rot_r[47:32];
  assign qw = rot_r[63:48];

  always_ff @(posedge clk) begin
    p_xx_r <= qx * qx;
    p_yy_r <= qy * qy;
    p_zz_r <= qz * qz;
    p_xy_r <= qx * qy;
    p_xz_r <= qx * qz;
    p_yz_r <= qy * qz;
    p_wx_r <= qw * qx;
    p_wy_r <= qw * qy;
    p_wz_r <= qw * qz;
  end

  assign e_xx = obpt_pkg::MAT_W'(p_xx_r);
  assign e_yy = obpt_pkg::MAT_W'(p_yy_r);
  assign e_zz = obpt_pkg::MAT_W'(p_zz_r);
  assign e_xy = obpt_pkg::MAT_W'(p_xy_r);
  assign e_xz = obpt_pkg::MAT_W'(p_xz_r);
  assign e_yz = obpt_pkg::MAT_W'(p_yz_r);
  assign e_wx = obpt_pkg::MAT_W'(p_wx_r);
  assign e_wy = obpt_pkg::MAT_W'(p_wy_r);
  assign e_wz = obpt_pkg::MAT_W'(p_wz_r);

  assign r00 = obpt_pkg::MAT_ONE - ((e_yy + e_zz) <<< 1);
  assign r01 = (e_xy - e_wz) <<< 1;
  assign r02 = (e_xz + e_wy) <<< 1;
  assign r10 = (e_xy + e_wz) <<< 1;
  assign r11 = obpt_pkg::MAT_ONE - ((e_xx + e_zz) <<< 1);
  assign r12 = (e_yz - e_wx) <<< 1;
  assign r20 = (e_xz - e_wy) <<< 1;
  assign r21 = (e_yz + e_wx) <<< 1;
  assign r22 = obpt_pkg::MAT_ONE - ((e_xx + e_yy) <<< 1);

  // hold the transpose: row i gives local axis i
  always_ff @(posedge clk) begin
    mat_r[0][0] <= r00;
    mat_r[0][1] <= r10;
    mat_r[0][2] <= r20;
    mat_r[1][0] <= r01;
    mat_r[1][1] <= r11;
    mat_r[1][2] <= r21;
    mat_r[2][0] <= r02;
    mat_r[2][1] <= r12;
    mat_r[2][2] <= r22;
  end

  assign cfg.center    = center_r;
  assign cfg.extent    = extent_r;
  assign cfg.min_count = min_count_r;
  assign cfg.mat       = mat_r;

endmodule

// ----- rtl/obpt_front.sv -----
`timescale 1ns / 1ps

module obpt_front (
  obpt_in_if.sink            in_ch,
  input  obpt_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_push,
  output obpt_pkg::q_word_t  q_word
);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_word.d[0]  = {in_ch.pos_x[31], in_ch.pos_x} - {cfg.center[0][31], cfg.center[0]};
    q_word.d[1]  = {in_ch.pos_y[31], in_ch.pos_y} - {cfg.center[1][31], cfg.center[1]};
    q_word.d[2]  = {in_ch.pos_z[31], in_ch.pos_z} - {cfg.center[2][31], cfg.center[2]};
    q_word.index = in_ch.particle_index;
    q_word.has   = in_ch.has_particle;
    q_word.last  = in_ch.frame_last;
  end

endmodule

// ----- rtl/obpt_queue.sv -----
`timescale 1ns / 1ps

module obpt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  obpt_pkg::q_word_t  push_word,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output obpt_pkg::q_word_t  head
);

  obpt_pkg::q_word_t               mem_r [obpt_pkg::Q_DEPTH];
  logic [obpt_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [obpt_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [obpt_pkg::Q_CNT_W-1:0]    cnt_r;

  assign full  = (cnt_r == obpt_pkg::Q_CNT_W'(obpt_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/obpt_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module obpt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  obpt_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  obpt_pkg::q_word_t  q_head,
  output logic               pop,
  obpt_out_if.source         out_ch
);

  obpt_pkg::bk_state_t state_r, state_nxt;

  obpt_pkg::q_word_t                     work_r;
  logic [1:0]                            axis_r;
  logic [2:0]                            step_r;
  logic                                  ins_r;
  logic signed [obpt_pkg::ACC_W-1:0]     acc_r;
  logic signed [obpt_pkg::PROD_W-1:0]    prod_r;
  logic                                  prod_hi_r;
  logic                                  prod_v_r;
  logic [obpt_pkg::CNT_W-1:0]            rc_r;
  logic                                  trig_r;

  logic                                  out_valid_r;
  logic                                  out_inside_r;
  logic [15:0]                           out_index_r;
  logic                                  out_done_r;
  logic [obpt_pkg::CNT_W-1:0]            out_count_r;
  logic                                  out_trig_r;
  logic                                  out_enter_r;
  logic                                  out_exit_r;

  logic                                  load_out;
  logic [1:0]                            term_j;
  logic                                  term_hi;
  logic signed [obpt_pkg::MAT_W-1:0]     mul_a;
  logic signed [obpt_pkg::HALF_W-1:0]    mul_b;
  logic [obpt_pkg::DIFF_W-1:0]           d_sel;
  logic signed [obpt_pkg::PROD_W-1:0]    prod_nxt;
  logic signed [obpt_pkg::ACC_W-1:0]     addend;
  logic signed [obpt_pkg::LOC_W:0]       loc;
  logic signed [obpt_pkg::LOC_W:0]       ext_s;
  logic                                  axis_ok;
  logic                                  ins_eff;
  logic [obpt_pkg::CNT_W-1:0]            cnt_nxt;
  logic                                  meet;
  logic                                  enter;
  logic                                  leave;
  logic                                  trig_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      obpt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_head.has ? obpt_pkg::BK_MAC : obpt_pkg::BK_FINISH;
        end
      end
      obpt_pkg::BK_MAC: begin
        if (step_r == obpt_pkg::MAC_LAST) begin
          state_nxt = obpt_pkg::BK_DRAIN;
        end
      end
      obpt_pkg::BK_DRAIN: begin
        state_nxt = obpt_pkg::BK_CHECK;
      end
      obpt_pkg::BK_CHECK: begin
        state_nxt = (axis_r == obpt_pkg::AXIS_LAST) ? obpt_pkg::BK_FINISH
                                                    : obpt_pkg::BK_MAC;
      end
      obpt_pkg::BK_FINISH: begin
        if (load_out) begin
          state_nxt = obpt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = obpt_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop      = (state_r == obpt_pkg::BK_IDLE) && !q_empty;
    load_out = (state_r == obpt_pkg::BK_FINISH) && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obpt_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // multiply one matrix entry by one half of a difference
  assign term_j  = step_r[2:1];
  assign term_hi = step_r[0];
  assign mul_a   = cfg.mat[axis_r][term_j];
  assign d_sel   = work_r.d[term_j];
  assign mul_b   = term_hi ? d_sel[obpt_pkg::DIFF_W-1:16] : {1'b0, d_sel[15:0]};
  assign prod_nxt = mul_a * mul_b;

  assign addend = prod_hi_r ? obpt_pkg::ACC_W'($signed({prod_r, 16'd0}))
                            : obpt_pkg::ACC_W'(prod_r);

  assign loc     = (obpt_pkg::LOC_W+1)'($signed(acc_r[obpt_pkg::ACC_W-1:obpt_pkg::FRAC_SHIFT]));
  assign ext_s   = $signed({11'd0, cfg.extent[axis_r]});
  assign axis_ok = (loc <= ext_s) && (loc >= -ext_s);

  always_ff @(posedge clk) begin
    if (pop) begin
      work_r <= q_head;
    end
    prod_r    <= prod_nxt;
    prod_hi_r <= term_hi;
    if (pop || state_r == obpt_pkg::BK_CHECK) begin
      acc_r <= obpt_pkg::ROUND_INIT;
    end else if (prod_v_r) begin
      acc_r <= acc_r + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r   <= '0;
      step_r   <= '0;
      ins_r    <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= (state_r == obpt_pkg::BK_MAC);
      if (pop) begin
        axis_r <= '0;
        step_r <= '0;
        ins_r  <= 1'b1;
      end else if (state_r == obpt_pkg::BK_MAC) begin
        step_r <= (step_r == obpt_pkg::MAC_LAST) ? 3'd0 : step_r + 3'd1;
      end else if (state_r == obpt_pkg::BK_CHECK) begin
        ins_r  <= ins_r & axis_ok;
        axis_r <= axis_r + 2'd1;
      end
    end
  end

  always_comb begin
    ins_eff  = work_r.has & ins_r;
    cnt_nxt  = (ins_eff && (rc_r < obpt_pkg::CNT_CAP)) ? rc_r + 1'b1 : rc_r;
    meet     = (cnt_nxt >= cfg.min_count);
    enter    = work_r.last && meet && !trig_r;
    leave    = work_r.last && !meet && trig_r;
    trig_nxt = enter | (trig_r & !leave);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= '0;
      trig_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        rc_r        <= work_r.last ? '0 : cnt_nxt;
        trig_r      <= trig_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_inside_r <= ins_eff;
      out_index_r  <= work_r.has ? work_r.index : 16'd0;
      out_done_r   <= work_r.last;
      out_count_r  <= work_r.last ? cnt_nxt : '0;
      out_trig_r   <= work_r.last && trig_nxt;
      out_enter_r  <= enter;
      out_exit_r   <= leave;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.inside_res    = out_inside_r;
  assign out_ch.index_out     = out_index_r;
  assign out_ch.frame_done    = out_done_r;
  assign out_ch.frame_count   = out_count_r;
  assign out_ch.triggered_now = out_trig_r;
  assign out_ch.enter_event   = out_enter_r;
  assign out_ch.exit_event    = out_exit_r;

  `OBPT_ASSERT(a_cnt_cap, rc_r <= obpt_pkg::CNT_CAP)
  `OBPT_ASSERT(a_evt_excl, out_valid_r |-> !(out_enter_r && out_exit_r))
  `OBPT_ASSERT(a_enter_trig, out_valid_r && out_enter_r |-> out_trig_r)
  `OBPT_ASSERT(a_pop_next, pop |=> state_r == obpt_pkg::BK_MAC || state_r == obpt_pkg::BK_FINISH)
  `OBPT_ASSERT(a_rc_clear, load_out && work_r.last |=> rc_r == '0)

endmodule

// ----- rtl/oriented_box_particle_trigger_top.sv -----
`timescale 1ns / 1ps
// Oriented box particle trigger. Each input word carries one Q16.16 particle
// position (or a bare frame end) and yields exactly one result word telling
// whether the particle lies inside the rotated box, plus, on the word marked
// frame_last, the saturated inside count and the trigger flag with its enter
// and exit pulses. The front subtracts the box center as a word is taken and
// places it in a two-word queue; in_ch.ready is high while that queue has
// room. The back forms each local coordinate with one shared 34x17 multiplier
// stepping through the three matrix terms in two halves. A particle word runs
// MAC, DRAIN and CHECK per axis, then FINISH; a bare frame end goes from IDLE
// to FINISH, which loads the output register when it is free. The queue is
// popped only in IDLE. A rotation write rebuilds the matrix through the
// product and matrix registers. Configuration writes are always accepted
// (cfg_ch.ready is high) and an unknown index is ignored.

module oriented_box_particle_trigger_top (
  input  logic          clk,
  input  logic          rst_n,
  obpt_in_if.sink       in_ch,
  obpt_out_if.source    out_ch,
  obpt_cfg_if.sink      cfg_ch
);

  obpt_pkg::cfg_t     cfg;
  obpt_pkg::q_word_t  push_word;
  obpt_pkg::q_word_t  q_head;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  obpt_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  obpt_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_word (push_word)
  );

  obpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  obpt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- bench/oriented_box_particle_trigger_top_tb.sv -----
`timescale 1ns / 1ps

module oriented_box_particle_trigger_top_tb;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int WORDS_PER_PHASE = 165;
  localparam int THRESH_WORDS = 40;
  localparam logic [3:0] CFG_SPARE_LO = 4'd8;
  localparam logic [3:0] CFG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic        inside_res;
    logic [15:0] index_out;
    logic        frame_done;
    logic [16:0] frame_count;
    logic        triggered_now;
    logic        enter_event;
    logic        exit_event;
  } trig_result_t;

  logic clk;
  logic rst_n;

  obpt_in_if  in_ch ();
  obpt_out_if out_ch ();
  obpt_cfg_if cfg_ch ();

  oriented_box_particle_trigger_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the box registers and the frame state
  logic signed [31:0] box_center [3];
  logic [30:0]        box_extent [3];
  logic [63:0]        box_quat;
  logic [16:0]        trig_min;
  logic [16:0]        inside_tally;
  logic               trig_active;

  trig_result_t awaited_results [$];
  trig_result_t oldest_result;
  int           errors;
  bit           idle_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("oriented_box_particle_trigger_top_tb: done, errors");
    $finish;
  end

  function automatic bit point_in_box(input logic signed [31:0] px, py, pz);
    logic signed [127:0] qx, qy, qz, qw, one, acc, bound;
    logic signed [127:0] d [3];
    logic signed [127:0] r [3][3];
    bit hit;
    int i;
    qx = 128'($signed(box_quat[15:0]));
    qy = 128'($signed(box_quat[31:16]));
    qz = 128'($signed(box_quat[47:32]));
    qw = 128'($signed(box_quat[63:48]));
    one = 128'sd1 <<< 28;
    d[0] = 128'(px) - 128'(box_center[0]);
    d[1] = 128'(py) - 128'(box_center[1]);
    d[2] = 128'(pz) - 128'(box_center[2]);
    r[0][0] = one - 128'sd2 * (qy * qy + qz * qz);
    r[0][1] = 128'sd2 * (qx * qy - qw * qz);
    r[0][2] = 128'sd2 * (qx * qz + qw * qy);
    r[1][0] = 128'sd2 * (qx * qy + qw * qz);
    r[1][1] = one - 128'sd2 * (qx * qx + qz * qz);
    r[1][2] = 128'sd2 * (qy * qz - qw * qx);
    r[2][0] = 128'sd2 * (qx * qz - qw * qy);
    r[2][1] = 128'sd2 * (qy * qz + qw * qx);
    r[2][2] = one - 128'sd2 * (qx * qx + qy * qy);
    hit = 1'b1;
    for (i = 0; i < 3; i++) begin
      acc = r[0][i] * d[0] + r[1][i] * d[1] + r[2][i] * d[2] + (128'sd1 <<< 27);
      acc = acc >>> 28;
      if (acc < 0) acc = -acc;
      bound = $signed({97'd0, box_extent[i]});
      if (acc > bound) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic trig_result_t predict_word_result(input logic signed [31:0] px, py, pz,
                                                       input logic [15:0] idx,
                                                       input logic has, last);
    trig_result_t res;
    logic hit;
    res = '0;
    if (has) begin
      hit = point_in_box(px, py, pz);
      if (hit && inside_tally < obpt_pkg::CNT_CAP) inside_tally = inside_tally + 17'd1;
      res.inside_res = hit;
      res.index_out  = idx;
    end
    if (last) begin
      res.frame_done  = 1'b1;
      res.frame_count = inside_tally;
      if (inside_tally >= trig_min && !trig_active) begin
        trig_active     = 1'b1;
        res.enter_event = 1'b1;
      end else if (inside_tally < trig_min && trig_active) begin
        trig_active    = 1'b0;
        res.exit_event = 1'b1;
      end
      res.triggered_now = trig_active;
      inside_tally = '0;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $error("result word with nothing awaited");
      end else begin
        oldest_result = awaited_results.pop_front();
        check_field("inside_res", 32'(oldest_result.inside_res), 32'(out_ch.inside_res));
        check_field("index_out", 32'(oldest_result.index_out), 32'(out_ch.index_out));
        check_field("frame_done", 32'(oldest_result.frame_done), 32'(out_ch.frame_done));
        check_field("frame_count", 32'(oldest_result.frame_count),
                    32'(out_ch.frame_count));
        check_field("triggered_now", 32'(oldest_result.triggered_now),
                    32'(out_ch.triggered_now));
        check_field("enter_event", 32'(oldest_result.enter_event),
                    32'(out_ch.enter_event));
        check_field("exit_event", 32'(oldest_result.exit_event), 32'(out_ch.exit_event));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [31:0] px, py, pz, input logic [15:0] idx,
                           input logic has, last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pos_x          <= px;
    in_ch.pos_y          <= py;
    in_ch.pos_z          <= pz;
    in_ch.particle_index <= idx;
    in_ch.has_particle   <= has;
    in_ch.frame_last     <= last;
    do @(posedge clk); while (!in_ch.ready);
    awaited_results.push_back(predict_word_result(px, py, pz, idx, has, last));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      obpt_pkg::CFG_CENTER_X:  box_center[0] = val[31:0];
      obpt_pkg::CFG_CENTER_Y:  box_center[1] = val[31:0];
      obpt_pkg::CFG_CENTER_Z:  box_center[2] = val[31:0];
      obpt_pkg::CFG_EXTENT_X:  box_extent[0] = val[30:0];
      obpt_pkg::CFG_EXTENT_Y:  box_extent[1] = val[30:0];
      obpt_pkg::CFG_EXTENT_Z:  box_extent[2] = val[30:0];
      obpt_pkg::CFG_ROTATION:  box_quat      = val;
      obpt_pkg::CFG_MIN_COUNT: trig_min      = val[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_box(input logic [31:0] cx, cy, cz, input logic [30:0] ex, ey, ez,
                           input logic [63:0] quat, input logic [16:0] min_cnt);
    write_reg(obpt_pkg::CFG_CENTER_X, {32'd0, cx});
    write_reg(obpt_pkg::CFG_CENTER_Y, {32'd0, cy});
    write_reg(obpt_pkg::CFG_CENTER_Z, {32'd0, cz});
    write_reg(obpt_pkg::CFG_EXTENT_X, {33'd0, ex});
    write_reg(obpt_pkg::CFG_EXTENT_Y, {33'd0, ey});
    write_reg(obpt_pkg::CFG_EXTENT_Z, {33'd0, ez});
    write_reg(obpt_pkg::CFG_ROTATION, quat);
    write_reg(obpt_pkg::CFG_MIN_COUNT, {47'd0, min_cnt});
  endtask

  // scatter around the center at about twice the largest extent, some words anywhere
  task automatic send_particle(input logic last);
    logic [31:0] p [3];
    longint span;
    int a;
    span = longint'(box_extent[0]);
    if (longint'(box_extent[1]) > span) span = longint'(box_extent[1]);
    if (longint'(box_extent[2]) > span) span = longint'(box_extent[2]);
    if (span > longint'(1 << 24)) span = longint'(1 << 24);
    span = span * 2 + 1;
    for (a = 0; a < 3; a++) begin
      if ($urandom_range(0, 7) == 0) p[a] = $urandom();
      else p[a] = box_center[a]
                  + 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
    end
    send_word(p[0], p[1], p[2], 16'($urandom()), 1'b1, last);
  endtask

  function automatic logic [63:0] pick_quat();
    case ($urandom_range(0, 5))
      0: return obpt_pkg::ROTATION_RESET;
      1: return {16'd11585, 16'd11585, 16'd0, 16'd0};
      2: return {16'd11585, 16'd0, 16'd0, 16'd11585};
      3: return {16'd8192, 16'd8192, 16'd8192, 16'd8192};
      4: return {16'd14189, 16'd0, 16'd8192, 16'd0};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic pick_box_setup(input int phase);
    logic [31:0] c [3];
    logic [30:0] e [3];
    logic [16:0] m;
    int a;
    for (a = 0; a < 3; a++) begin
      if (phase % 4 == 3) c[a] = $urandom();
      else c[a] = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
      if (phase % 4 == 2) e[a] = 31'($urandom());
      else if ($urandom_range(0, 9) == 0) e[a] = '0;
      else e[a] = 31'($urandom_range(0, 1 << 24));
    end
    if (phase == 5) m = 17'($urandom_range(0, 32'(obpt_pkg::CNT_CAP)));
    else m = 17'($urandom_range(0, 4));
    write_box(c[0], c[1], c[2], e[0], e[1], e[2], pick_quat(), m);
  endtask

  task automatic test_default_box();
    send_word(32'd0, 32'd0, 32'd0, 16'h0000, 1'b1, 1'b0);
    send_word(32'd6553600, -32'sd6553600, 32'd6553600, 16'hFFFF, 1'b1, 1'b0);
    send_word(32'd6553601, 32'd0, 32'd0, 16'h5A5A, 1'b1, 1'b0);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hA5A5, 1'b1, 1'b1);
    send_word($urandom(), $urandom(), $urandom(), 16'($urandom()), 1'b0, 1'b1);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h1234, 1'b1, 1'b1);
    send_word($urandom(), $urandom(), $urandom(), 16'($urandom()), 1'b0, 1'b0);
  endtask

  task automatic test_register_extremes();
    wait_for_results();
    write_box(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
              obpt_pkg::ROTATION_RESET, 17'd0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'h0001, 1'b1, 1'b1);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h8000, 1'b1, 1'b1);
    send_word(32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1);
    wait_for_results();
    write_reg(obpt_pkg::CFG_ROTATION, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    write_reg(obpt_pkg::CFG_MIN_COUNT, {47'd0, obpt_pkg::CNT_CAP});
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'h00FF, 1'b1, 1'b1);
    wait_for_results();
    write_box(32'd0, 32'd0, 32'd0, 31'd6553600, 31'd65536, 31'd6553600,
              {16'd11585, 16'd11585, 16'd0, 16'd0}, 17'd1);
    send_word(32'd65536, 32'd6553600, 32'd0, 16'h0F0F, 1'b1, 1'b0);
    send_word(32'd6553600, 32'd65536, 32'd0, 16'hF0F0, 1'b1, 1'b1);
  endtask

  task automatic test_unknown_index();
    wait_for_results();
    write_reg(CFG_SPARE_LO, {$urandom(), $urandom()});
    write_reg(CFG_SPARE_HI, {$urandom(), $urandom()});
    send_word(32'd6553600, 32'd65536, 32'd0, 16'h3C3C, 1'b1, 1'b1);
    send_word(32'd0, 32'd0, 32'd0, 16'hC3C3, 1'b1, 1'b1);
  endtask

  task automatic test_count_threshold();
    int n;
    wait_for_results();
    idle_en = 1'b0;
    write_box(32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
              obpt_pkg::ROTATION_RESET, 17'(THRESH_WORDS));
    for (n = 0; n < THRESH_WORDS; n++)
      send_word($urandom() & 32'h7FFF_FFFF, $urandom() & 32'h7FFF_FFFF,
                $urandom() & 32'h7FFF_FFFF, 16'($urandom()), 1'b1,
                n == THRESH_WORDS - 1);
    for (n = 0; n < THRESH_WORDS; n++)
      send_word($urandom() & 32'h7FFF_FFFF, $urandom() & 32'h7FFF_FFFF,
                $urandom() & 32'h7FFF_FFFF, 16'($urandom()), n != 0,
                n == THRESH_WORDS - 1);
    idle_en = 1'b1;
  endtask

  task automatic test_random_frames();
    int phase, sent, flen, k, hold_at;
    bit bare_end, held;
    for (phase = 0; phase < 8; phase++) begin
      wait_for_results();
      idle_en = (phase < 6);
      pick_box_setup(phase);
      sent = 0;
      held = 1'b0;
      hold_at = $urandom_range(20, 150);
      while (sent < WORDS_PER_PHASE) begin
        flen = $urandom_range(0, 12);
        bare_end = (flen == 0) || ($urandom_range(0, 3) == 0);
        for (k = 0; k < flen; k++) begin
          send_particle(!bare_end && k == flen - 1);
          sent++;
        end
        if (bare_end) begin
          send_word($urandom(), $urandom(), $urandom(), 16'($urandom()), 1'b0, 1'b1);
          sent++;
        end
        if ($urandom_range(0, 9) == 0)
          send_word($urandom(), $urandom(), $urandom(), 16'($urandom()),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (!held && sent >= hold_at) begin
          wait_for_results();
          held = 1'b1;
        end
      end
    end
  endtask

  initial begin
    errors = 0;
    idle_en = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.particle_index = '0;
    in_ch.has_particle = 1'b0;
    in_ch.frame_last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    box_center[0] = '0;
    box_center[1] = '0;
    box_center[2] = '0;
    box_extent[0] = obpt_pkg::EXTENT_RESET;
    box_extent[1] = obpt_pkg::EXTENT_RESET;
    box_extent[2] = obpt_pkg::EXTENT_RESET;
    box_quat = obpt_pkg::ROTATION_RESET;
    trig_min = obpt_pkg::MIN_COUNT_RESET;
    inside_tally = '0;
    trig_active = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_box();
    test_register_extremes();
    test_unknown_index();
    test_count_threshold();
    test_random_frames();
    wait_for_results();
    repeat (40) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("oriented_box_particle_trigger_top_tb: done, clean");
    end else begin
      $display("oriented_box_particle_trigger_top_tb: done, errors");
    end
    $finish;
  end

endmodule
